// ----- src/sct_pkg.sv -----
`timescale 1ns / 1ps
// sct_pkg: widths, constants, command/status types and the denominator
// function shared by the fixed-point sine/cosine block. No dependencies.
package sct_pkg;

  // Port widths.
  localparam int ANG_W = 32;
  localparam int VAL_W = 30;

  // Internal widths, sized for FRAC_BITS anywhere in 16..30.
  localparam int XW     = 35;  // angle during range reduction
  localparam int UXW    = 32;  // |x| after reduction
  localparam int X2W    = 34;  // x squared
  localparam int TW     = 36;  // signed series term
  localparam int MAGW   = 36;  // multiplier operand
  localparam int HALF   = MAGW / 2;
  localparam int PP_W   = HALF + MAGW;
  localparam int PROD_W = 2 * MAGW;
  localparam int PW     = 40;  // |p| before divide
  localparam int SUMW   = 40;  // running sum
  localparam int DW     = 11;  // denominator, up to 32*33
  localparam int DIV_R  = 8;   // quotient bits per divider cycle
  localparam int DIV_CYC   = PW / DIV_R;
  localparam int DIV_CNT_W = $clog2(DIV_CYC);
  localparam int STEP_W = 5;

  // pi and 2pi with 30 fraction bits.
  localparam logic [63:0] PI_Q30     = 64'd3373259426;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_REDUCE,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_MUL_ACC,
    OP_INIT,
    OP_DIV_START,
    OP_UPDATE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   mul_sq;    // square x instead of term * x2
    step_t  step;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic div_last;
  } dp_status_t;

  // Round a Q30 constant to frac fraction bits.
  function automatic logic [63:0] q_const(input int frac, input logic [63:0] q30);
    logic [63:0] half;
    half = (64'd1 << (30 - frac)) >> 1;
    return (q30 + half) >> (30 - frac);
  endfunction

  // Series denominator for step i: (2i)(2i+1) for sine, (2i-1)(2i) for cosine.
  function automatic logic [DW-1:0] d_of(input logic cos, input step_t i);
    logic [DW-1:0] n;
    n = DW'({i, 1'b0});
    return cos ? n * (n - DW'(1)) : n * (n + DW'(1));
  endfunction

endpackage

// ----- src/sine_cosine_taylor_fixed.sv -----
`timescale 1ns / 1ps
// Fixed-point sine/cosine by Taylor series, top level.
// Depends on sct_pkg, sct_ctrl and sct_datapath.
//
// Each request carries a command (0 sine, 1 cosine) and a signed angle in
// radians with FRAC_BITS fraction bits (Q3.28 by default). The angle is
// first folded into [-pi, pi] by adding or subtracting 2pi, one correction
// per cycle. TERMS series terms are then summed in wide fixed point: each
// step multiplies the previous term by x^2 (floor shift by FRAC_BITS) and
// divides by the step's factorial ratio with truncation toward zero. The
// sum is clamped to +/-1.0 and returned with FRAC_BITS fraction bits in
// the 30-bit value field (+1.0 wraps from FRAC_BITS = 29, -1.0 at 30).
// One request is worked on at a time, and the time it takes grows with the
// number of 2pi corrections. The cost is set by the series loop: per term,
// two passes through one shared 18x36 multiplier plus an accumulate, and a
// run of an 8-bit-per-cycle divider over the 40-bit dividend. A finished
// result sits in an output register, so a new request is taken while the
// previous result still waits.
module sine_cosine_taylor_fixed #(
  parameter int TERMS     = 10,
  parameter int FRAC_BITS = 28
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             command_i,
  input  logic signed [sct_pkg::ANG_W-1:0] angle_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [sct_pkg::VAL_W-1:0] value_o
);
  import sct_pkg::*;

  localparam logic signed [31:0] ONE32 = 32'sd1 <<< FRAC_BITS;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Controller: sequencing and both handshakes.
  sct_ctrl #(
    .TERMS (TERMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Datapath: reduction, multiplier, divider, sum and output register.
  sct_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .command_i (command_i),
    .angle_i   (angle_i),
    .value_o   (value_o)
  );

  logic signed [31:0] value_sx;
  assign value_sx = 32'(value_o);

  // A taken request keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted again right after a request");

  // A new result only appears out of the finishing phase, never from idle.
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a request in flight");

  // Clamp keeps every result within +/-1.0 (not checked at FRAC_BITS = 30).
  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (FRAC_BITS >= 30) || (value_sx <= ONE32 && value_sx >= -ONE32))
    else $error("result outside +/-1.0");

endmodule

// ----- src/sct_div.sv -----
`timescale 1ns / 1ps
// sct_div: unsigned iterative divider, DIV_R quotient bits per cycle.
// Depends on sct_pkg.
module sct_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [sct_pkg::PW-1:0]  dvd_i,
  input  logic [sct_pkg::DW-1:0]  dsr_i,
  output logic                    last_o,
  output logic [sct_pkg::PW-1:0]  quot_o
);
  import sct_pkg::*;

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [PW-1:0]        dvd_q;
  logic [DW-1:0]        rem_q, dsr_q;
  logic [DW-1:0]        rem_d;
  logic [DIV_R-1:0]     qbits;

  // Restoring division over DIV_R dividend bits; remainder stays below dsr.
  always_comb begin
    logic [DW:0] t;
    rem_d = rem_q;
    qbits = '0;
    for (int k = 0; k < DIV_R; k++) begin
      t = {rem_d, dvd_q[PW-1-k]};
      if (t >= {1'b0, dsr_q}) begin
        t = t - {1'b0, dsr_q};
        qbits[DIV_R-1-k] = 1'b1;
      end
      rem_d = t[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_CNT_W'(DIV_CYC - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dvd_i;
      dsr_q <= dsr_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[PW-DIV_R-1:0], qbits};
      rem_q <= rem_d;
    end
  end

  assign last_o = busy_q && (cnt_q == '0);
  assign quot_o = dvd_q;

endmodule

// ----- src/sct_datapath.sv -----
`timescale 1ns / 1ps
// sct_datapath: angle reduction, shared split multiplier, divider, term and
// sum registers, output clamp. Depends on sct_pkg and sct_div.
module sct_datapath #(
  parameter int FRAC_BITS = 28
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sct_pkg::dp_cmd_t                 cmd_i,
  output sct_pkg::dp_status_t              status_o,
  input  logic                             command_i,
  input  logic signed [sct_pkg::ANG_W-1:0] angle_i,
  output logic signed [sct_pkg::VAL_W-1:0] value_o
);
  import sct_pkg::*;

  localparam logic signed [XW-1:0]   PI_X     = signed'(XW'(q_const(FRAC_BITS, PI_Q30)));
  localparam logic signed [XW-1:0]   NEG_PI_X = -PI_X;
  localparam logic signed [XW-1:0]   TWO_PI_X = signed'(XW'(q_const(FRAC_BITS, TWO_PI_Q30)));
  localparam logic signed [TW-1:0]   ONE_T    = signed'(TW'(64'd1 << FRAC_BITS));
  localparam logic signed [SUMW-1:0] ONE_S    = signed'(SUMW'(64'd1 << FRAC_BITS));
  localparam logic signed [SUMW-1:0] NEG_ONE_S = -ONE_S;

  logic                     cos_q;
  logic signed [XW-1:0]     x_q;
  logic [X2W-1:0]           x2_q;
  logic signed [TW-1:0]     term_q;
  logic signed [SUMW-1:0]   sum_q;
  logic [PP_W-1:0]          pp_q;
  logic [PROD_W-1:0]        acc_q;
  logic signed [VAL_W-1:0]  value_q;

  logic [UXW-1:0]           ux;
  logic                     term_neg;
  logic [MAGW-1:0]          term_mag, op_a, op_b;
  logic [HALF-1:0]          a_half;
  logic [PP_W-1:0]          mult;
  logic [PW-1:0]            p_mag, quot;
  logic [DW-1:0]            dsr;
  logic signed [TW-1:0]     q_t, term_new;
  logic signed [SUMW-1:0]   sum_sat;
  logic                     div_last;

  assign ux       = x_q[XW-1] ? UXW'(-x_q) : UXW'(x_q);
  assign term_neg = term_q[TW-1];
  assign term_mag = term_neg ? MAGW'(-term_q) : MAGW'(term_q);

  // One 18 x 36 multiplier; a full product takes a low and a high pass.
  assign op_a   = cmd_i.mul_sq ? MAGW'(ux) : term_mag;
  assign op_b   = cmd_i.mul_sq ? MAGW'(ux) : MAGW'(x2_q);
  assign a_half = (cmd_i.op == OP_MUL_HI) ? op_a[MAGW-1:HALF] : op_a[HALF-1:0];
  assign mult   = PP_W'(a_half) * PP_W'(op_b);

  // floor(term * x2 / 2^F) as magnitude; a negative term rounds away.
  assign p_mag = PW'(acc_q >> FRAC_BITS)
               + PW'(term_neg && (acc_q[FRAC_BITS-1:0] != '0));
  assign dsr   = d_of(cos_q, cmd_i.step);

  sct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_DIV_START),
    .dvd_i   (p_mag),
    .dsr_i   (dsr),
    .last_o  (div_last),
    .quot_o  (quot)
  );

  // -p / d truncated: the sign flips against the old term.
  assign q_t      = signed'(TW'(quot));
  assign term_new = term_neg ? q_t : -q_t;

  always_comb begin
    priority if (sum_q > ONE_S) sum_sat = ONE_S;
    else if (sum_q < NEG_ONE_S) sum_sat = NEG_ONE_S;
    else sum_sat = sum_q;
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        cos_q <= command_i;
        x_q   <= XW'(angle_i);
      end
      OP_REDUCE: begin
        if (x_q > PI_X) x_q <= x_q - TWO_PI_X;
        else if (x_q < NEG_PI_X) x_q <= x_q + TWO_PI_X;
      end
      OP_MUL_LO: pp_q <= mult;
      OP_MUL_HI: begin
        acc_q <= PROD_W'(pp_q);
        pp_q  <= mult;
      end
      OP_MUL_ACC: acc_q <= acc_q + (PROD_W'(pp_q) << HALF);
      OP_INIT: begin
        x2_q   <= X2W'(acc_q >> FRAC_BITS);
        term_q <= cos_q ? ONE_T : TW'(x_q);
        sum_q  <= cos_q ? SUMW'(ONE_T) : SUMW'(x_q);
      end
      OP_UPDATE: begin
        term_q <= term_new;
        sum_q  <= sum_q + SUMW'(term_new);
      end
      OP_IDLE, OP_DIV_START: ;
      default: ;
    endcase
    if (cmd_i.out_load) value_q <= VAL_W'(sum_sat);
  end

  assign status_o.in_range = !(x_q > PI_X) && !(x_q < NEG_PI_X);
  assign status_o.div_last = div_last;
  assign value_o           = value_q;

endmodule

// ----- src/sct_ctrl.sv -----
`timescale 1ns / 1ps
// sct_ctrl: sequencer for reduction, squaring and the series steps, plus
// input/output handshakes. Depends on sct_pkg.
module sct_ctrl #(
  parameter int TERMS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sct_pkg::dp_cmd_t    cmd_o,
  input  sct_pkg::dp_status_t status_i
);
  import sct_pkg::*;

  localparam int SW = $clog2(TERMS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_REDUCE,
    S_SQ_LO,
    S_SQ_HI,
    S_SQ_ACC,
    S_INIT,
    S_TM_LO,
    S_TM_HI,
    S_TM_ACC,
    S_DIV_START,
    S_DIV_WAIT,
    S_UPDATE,
    S_DONE
  } state_e;

  state_e        state_q;
  logic [SW-1:0] step_q;
  logic          out_valid_q;

  always_comb begin
    cmd_o.op       = OP_IDLE;
    cmd_o.mul_sq   = 1'b0;
    cmd_o.step     = STEP_W'(step_q);
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      S_IDLE:      if (in_valid_i) cmd_o.op = OP_LOAD;
      S_REDUCE:    cmd_o.op = OP_REDUCE;
      S_SQ_LO: begin
        cmd_o.op     = OP_MUL_LO;
        cmd_o.mul_sq = 1'b1;
      end
      S_SQ_HI: begin
        cmd_o.op     = OP_MUL_HI;
        cmd_o.mul_sq = 1'b1;
      end
      S_SQ_ACC: begin
        cmd_o.op     = OP_MUL_ACC;
        cmd_o.mul_sq = 1'b1;
      end
      S_INIT:      cmd_o.op = OP_INIT;
      S_TM_LO:     cmd_o.op = OP_MUL_LO;
      S_TM_HI:     cmd_o.op = OP_MUL_HI;
      S_TM_ACC:    cmd_o.op = OP_MUL_ACC;
      S_DIV_START: cmd_o.op = OP_DIV_START;
      S_DIV_WAIT:  cmd_o.op = OP_IDLE;
      S_UPDATE:    cmd_o.op = OP_UPDATE;
      S_DONE:      cmd_o.out_load = !out_valid_q || out_ready_i;
      default:     cmd_o.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE:      if (in_valid_i) state_q <= S_REDUCE;
        S_REDUCE:    if (status_i.in_range) state_q <= S_SQ_LO;
        S_SQ_LO:     state_q <= S_SQ_HI;
        S_SQ_HI:     state_q <= S_SQ_ACC;
        S_SQ_ACC:    state_q <= S_INIT;
        S_INIT: begin
          step_q  <= SW'(1);
          state_q <= S_TM_LO;
        end
        S_TM_LO:     state_q <= S_TM_HI;
        S_TM_HI:     state_q <= S_TM_ACC;
        S_TM_ACC:    state_q <= S_DIV_START;
        S_DIV_START: state_q <= S_DIV_WAIT;
        S_DIV_WAIT:  if (status_i.div_last) state_q <= S_UPDATE;
        S_UPDATE: begin
          if (step_q == SW'(TERMS)) begin
            state_q <= S_DONE;
          end else begin
            step_q  <= step_q + SW'(1);
            state_q <= S_TM_LO;
          end
        end
        S_DONE:      if (cmd_o.out_load) state_q <= S_IDLE;
        default:     state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- bench/sine_cosine_taylor_fixed_tb.sv -----
`timescale 1ns / 1ps
// Testbench for sine_cosine_taylor_fixed: a directed table, then random requests.
// Results are checked against typed-in values on fixed rows, else an in-bench fixed-point series predictor.
// Depends on sct_pkg and the sine_cosine_taylor_fixed RTL.
module sine_cosine_taylor_fixed_tb;

  import sct_pkg::*;

  // Block configuration under test (defaults of the top level).
  localparam int TERMS = 10;
  localparam int FRAC  = 28;
  localparam int SH    = 30 - FRAC;

  // pi and 2pi rounded from the Q30 values to FRAC fraction bits, pi/2 as half of that pi, and 1.0.
  localparam longint PI_FX     = longint'((PI_Q30 + ((64'd1 << SH) >> 1)) >> SH);
  localparam longint TWO_PI_FX = longint'((TWO_PI_Q30 + ((64'd1 << SH) >> 1)) >> SH);
  localparam longint HALF_PI_FX = PI_FX / 2;
  localparam longint ONE_FX     = longint'(1) << FRAC;
  localparam logic [VAL_W-1:0] VAL_ONE  = VAL_W'(ONE_FX);
  localparam logic [VAL_W-1:0] VAL_ZERO = '0;

  localparam int RANDOM_REQS = 1700;
  localparam int HOLD_CYCLES = 600;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 150;  // > one full series pass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    command_i;
  logic signed [ANG_W-1:0] angle_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [VAL_W-1:0] value_o;

  sine_cosine_taylor_fixed #(
    .TERMS    (TERMS),
    .FRAC_BITS(FRAC)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .angle_i    (angle_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Values still owed by the block, oldest first.
  logic [VAL_W-1:0] pending_values[$];
  logic [VAL_W-1:0] want_value;
  int               errors = 0;
  bit               hold_req = 1'b0;

  // Series predictor: fold the angle into [-pi, pi], then sum TERMS terms.
  // Each step: p = floor(term * x2 / 2^F) on the full product, then
  // term = -p / d truncated toward zero. Sum clamped to +/-1.0.
  function automatic logic [VAL_W-1:0] taylor_value(input logic cos_sel,
                                                    input logic signed [ANG_W-1:0] ang);
    longint          x, term, sum, p, d;
    longint unsigned ux, x2;
    logic [127:0]    mag, prod, q;
    logic            neg;
    x = longint'(ang);
    while (x > PI_FX) x -= TWO_PI_FX;
    while (x < -PI_FX) x += TWO_PI_FX;
    ux = longint'(x < 0 ? -x : x);
    x2 = (ux * ux) >> FRAC;
    term = cos_sel ? ONE_FX : x;
    sum = term;
    for (int i = 1; i <= TERMS; i++) begin
      d = cos_sel ? longint'(2 * i - 1) * longint'(2 * i)
                  : longint'(2 * i) * longint'(2 * i + 1);
      neg = term < 0;
      mag = 128'(neg ? -term : term);
      prod = mag * 128'(x2);
      q = prod >> FRAC;
      if (q > (128'd1 << 62)) q = 128'd1 << 62;
      // floor of a negative product rounds its magnitude up
      if (neg) p = -(longint'(q) + longint'((prod & ((128'd1 << FRAC) - 1)) != 0));
      else p = longint'(q);
      term = -p / d;
      sum += term;
    end
    if (sum > ONE_FX) sum = ONE_FX;
    if (sum < -ONE_FX) sum = -ONE_FX;
    return sum[VAL_W-1:0];
  endfunction

  // Idle lengths: mostly none or short, a few long.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random angles, weighted toward the folding boundaries, zero and the peaks.
  function automatic logic [ANG_W-1:0] pick_angle();
    int unsigned r;
    int          a;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2: a = int'($urandom());
      3, 4, 5: a = int'($urandom_range(0, 32'(2 * PI_FX))) - int'(PI_FX);
      6: a = ($urandom_range(0, 1) ? int'(PI_FX) : -int'(PI_FX))
             + int'($urandom_range(0, 16)) - 8;
      7: a = ($urandom_range(0, 1) ? int'(TWO_PI_FX) : -int'(TWO_PI_FX))
             + int'($urandom_range(0, 4096)) - 2048;
      8: a = int'($urandom_range(0, 2048)) - 1024;
      default: a = ($urandom_range(0, 1) ? int'(HALF_PI_FX) : -int'(HALF_PI_FX))
                   + int'($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
    return a;
  endfunction

  // Offer one request after gap idle cycles and wait for it to be taken.
  // The expectation is recorded at the accepting edge: a typed-in value
  // for fixed rows, otherwise the predictor's.
  task automatic send_req(input logic cmd, input logic [ANG_W-1:0] ang,
                          input logic fixed, input logic [VAL_W-1:0] fixed_val,
                          input int gap);
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    angle_i    <= ang;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_values.push_back(fixed ? fixed_val : taylor_value(cmd, ang));
  endtask

  // Directed table. fixed = 1 rows carry a value read straight off the
  // math: sin 0 = 0 and cos 0 = 1.0, also after folding +/-2pi to zero.
  typedef struct packed {
    logic             cmd;
    logic [ANG_W-1:0] ang;
    logic             fixed;
    logic [VAL_W-1:0] val;
  } dir_row_t;

  localparam int DIR_ROWS = 22;
  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{1'b0, 32'sd0,                       1'b1, VAL_ZERO},
    '{1'b1, 32'sd0,                       1'b1, VAL_ONE},
    '{1'b0, ANG_W'(TWO_PI_FX),            1'b1, VAL_ZERO},
    '{1'b1, ANG_W'(TWO_PI_FX),            1'b1, VAL_ONE},
    '{1'b0, ANG_W'(-TWO_PI_FX),           1'b1, VAL_ZERO},
    '{1'b1, ANG_W'(-TWO_PI_FX),           1'b1, VAL_ONE},
    // extremes of the angle field, both fold once
    '{1'b0, 32'h7fff_ffff,                1'b0, VAL_ZERO},
    '{1'b1, 32'h7fff_ffff,                1'b0, VAL_ZERO},
    '{1'b0, 32'h8000_0000,                1'b0, VAL_ZERO},
    '{1'b1, 32'h8000_0000,                1'b0, VAL_ZERO},
    // exactly +/-pi stays, one LSB beyond folds
    '{1'b0, ANG_W'(PI_FX),                1'b0, VAL_ZERO},
    '{1'b1, ANG_W'(PI_FX),                1'b0, VAL_ZERO},
    '{1'b0, ANG_W'(-PI_FX),               1'b0, VAL_ZERO},
    '{1'b1, ANG_W'(-PI_FX),               1'b0, VAL_ZERO},
    '{1'b0, ANG_W'(PI_FX + 1),            1'b0, VAL_ZERO},
    '{1'b1, ANG_W'(-PI_FX - 1),           1'b0, VAL_ZERO},
    // peaks, where the sum may need clamping
    '{1'b0, ANG_W'(HALF_PI_FX),           1'b0, VAL_ZERO},
    '{1'b0, ANG_W'(-HALF_PI_FX),          1'b0, VAL_ZERO},
    '{1'b1, ANG_W'(HALF_PI_FX),           1'b0, VAL_ZERO},
    // one LSB
    '{1'b0, 32'sd1,                       1'b0, VAL_ZERO},
    '{1'b0, 32'hffff_ffff,                1'b0, VAL_ZERO},
    '{1'b1, 32'sd1,                       1'b0, VAL_ZERO}
  };

  // Stimulus and end of run.
  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    command_i  = 1'b0;
    angle_i    = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_req(dir_rows[i].cmd, dir_rows[i].ang, dir_rows[i].fixed, dir_rows[i].val,
               pick_gap());

    // Ask the receiver for its long hold-off while requests keep coming.
    hold_req = 1'b1;
    for (int i = 0; i < RANDOM_REQS; i++)
      send_req(1'($urandom_range(0, 1)), pick_angle(), 1'b0, VAL_ZERO,
               ((i / 150) % 4 == 3) ? 0 : pick_gap());
    @(negedge clk_i) in_valid_i <= 1'b0;

    while (pending_values.size() != 0) @(posedge clk_i);
    // Any stray extra result would show up in this window.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("sine_cosine_taylor_fixed_tb: PASS");
    end else begin
      $display("sine_cosine_taylor_fixed_tb: FAIL");
    end
    $finish;
  end

  // Receiver: random stalls, stretches always ready, one long hold-off.
  initial begin
    int  low, high;
    bit  held;
    out_ready_i = 1'b0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        low  = HOLD_CYCLES;
        high = 1;
      end else if ($urandom_range(0, 9) == 0) begin
        low  = 0;
        high = $urandom_range(100, 300);
      end else begin
        low  = pick_gap();
        high = $urandom_range(1, 8);
      end
      if (low > 0) begin
        @(negedge clk_i) out_ready_i <= 1'b0;
        repeat (low - 1) @(negedge clk_i);
      end
      @(negedge clk_i) out_ready_i <= 1'b1;
      repeat (high - 1) @(negedge clk_i);
    end
  end

  // Result checker: each taken result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_values.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none got %0d", $time, value_o);
      end else begin
        want_value = pending_values.pop_front();
        if (value_o !== want_value) begin
          errors++;
          $display("%0t: value mismatch, expected %0d got %0d", $time,
                   $signed(want_value), value_o);
        end
      end
    end
  end

  // Watchdog: ends the run as a failure if it does not finish in time.
  initial begin
    #25ms;
    $display("sine_cosine_taylor_fixed_tb: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/sct_pkg.sv
src/sct_div.sv
src/sct_datapath.sv
src/sct_ctrl.sv
src/sine_cosine_taylor_fixed.sv
bench/sine_cosine_taylor_fixed_tb.sv
